>>> hdl/mnep_pkg.sv
// shared types, constants and arithmetic helpers for the midi note event parser
package mnep_pkg;

    localparam logic [7:0] ST_NOTE_ON = 8'h90;
    localparam logic [7:0] ST_CTRL    = 8'hB0;
    localparam logic [7:0] ST_ALIVE   = 8'hFE;
    localparam logic [8:0] VEL_MAX    = 9'h07F;

    localparam logic [3:0] CTRL_SKIP_RESET = 4'd6;

    // reciprocal of five scaled by 2^10, exact for any byte
    localparam logic [7:0] DIV5_MUL   = 8'd205;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_KEY  = 2'd1,
        PH_VEL  = 2'd2,
        PH_SKIP = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_KEY_ON  = 2'd0,
        EV_KEY_OFF = 2'd1,
        EV_CTRL    = 2'd2,
        EV_ALL_OFF = 2'd3
    } ev_code_t;

    typedef struct packed {
        ev_code_t   code;
        logic [7:0] note_or_value;
        logic [7:0] attenuation;
        logic       last;
    } result_t;

    // results produced by one accepted byte
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    typedef struct packed {
        logic [2:0] count;
    } q_status_t;

    function automatic logic [7:0] div5(input logic [7:0] x);
        logic [15:0] p;
        p = x * DIV5_MUL;
        return {2'b00, p[15:10]};
    endfunction

    // (127 - vel) / 5 truncated toward zero, as a two's-complement byte
    function automatic logic [7:0] atten_of(input logic [7:0] vel);
        logic [8:0] diff;
        logic [7:0] mag;
        logic [7:0] q;
        diff = VEL_MAX - {1'b0, vel};
        mag  = diff[8] ? 8'(9'd0 - diff) : diff[7:0];
        q    = div5(mag);
        return diff[8] ? 8'(8'd0 - q) : q;
    endfunction

endpackage

>>> hdl/mnep_parser.sv
// message position tracking, voice counter and result generation
module mnep_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [7:0]        rx_byte,
    input  logic              cfg_wr_en,
    input  logic [3:0]        cfg_wr_data,
    output mnep_pkg::push_t   push
);
    import mnep_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] key_reg, key_next;
    logic [7:0] voices_reg, voices_next;
    logic [7:0] val_reg, val_next;
    logic [7:0] att_reg, att_next;
    logic [3:0] skip_reg, skip_next;
    logic [3:0] skip_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            key_reg      <= '0;
            voices_reg   <= '0;
            val_reg      <= '0;
            att_reg      <= '0;
            skip_reg     <= '0;
            skip_cnt_reg <= CTRL_SKIP_RESET;
        end else begin
            phase_reg  <= phase_next;
            key_reg    <= key_next;
            voices_reg <= voices_next;
            val_reg    <= val_next;
            att_reg    <= att_next;
            skip_reg   <= skip_next;
            if (cfg_wr_en) begin
                skip_cnt_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        key_next    = key_reg;
        voices_next = voices_reg;
        val_next    = val_reg;
        att_next    = att_reg;
        skip_next   = skip_reg;
        push.n      = 2'd0;
        push.r0     = '0;
        push.r1     = '0;
        if (in_accept) begin
            case (phase_reg)
                PH_KEY: begin
                    key_next   = rx_byte;
                    phase_next = PH_VEL;
                end
                PH_VEL: begin
                    phase_next = PH_IDLE;
                    val_next   = key_reg;
                    if (rx_byte != 8'd0) begin
                        att_next    = atten_of(rx_byte);
                        voices_next = voices_reg + 8'd1;
                        push.n      = 2'd1;
                        push.r0     = '{EV_KEY_ON, key_reg, att_next, 1'b1};
                    end else begin
                        voices_next = voices_reg - 8'd1;
                        if (voices_next == 8'd0) begin
                            push.n  = 2'd2;
                            push.r0 = '{EV_KEY_OFF, key_reg, att_reg, 1'b0};
                            push.r1 = '{EV_ALL_OFF, key_reg, att_reg, 1'b1};
                        end else begin
                            push.n  = 2'd1;
                            push.r0 = '{EV_KEY_OFF, key_reg, att_reg, 1'b1};
                        end
                    end
                end
                PH_SKIP: begin
                    if (skip_reg > 4'd1) begin
                        skip_next = skip_reg - 4'd1;
                    end else begin
                        skip_next  = 4'd0;
                        phase_next = PH_IDLE;
                        val_next   = rx_byte;
                        push.n     = 2'd1;
                        push.r0    = '{EV_CTRL, rx_byte, att_reg, 1'b1};
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    if (rx_byte == ST_ALIVE) begin
                        phase_next = PH_IDLE;
                    end else if (rx_byte == ST_NOTE_ON) begin
                        phase_next = PH_KEY;
                    end else if (rx_byte == ST_CTRL) begin
                        // a zero count behaves as one
                        skip_next  = (skip_cnt_reg == 4'd0) ? 4'd1 : skip_cnt_reg;
                        phase_next = PH_SKIP;
                    end else begin
                        // running status: byte is the key
                        key_next   = rx_byte;
                        phase_next = PH_VEL;
                    end
                end
            endcase
        end
    end

endmodule

>>> hdl/mnep_out_queue.sv
// four-entry result queue, takes up to two results a cycle, gives one
module mnep_out_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mnep_pkg::push_t      push,
    input  logic                 pop,
    output mnep_pkg::result_t    head,
    output mnep_pkg::q_status_t  status
);
    import mnep_pkg::*;

    result_t    mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.n} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem_reg[wr_ptr_reg + 2'd1] <= push.r1;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.count = count_reg;

endmodule

>>> hdl/midi_note_event_parser.sv
// top level of the midi note event parser
//
//  channel   dir  tdata                                  tuser             tlast
//  s_axis    in   [7:0] rx_byte                          -                 -
//  m_axis    out  [7:0] note_or_value,                   [1:0] event_code  last_of_run
//                 [15:8] attenuation
//  cfg       in   cfg_wr_data[3:0] control_skip_count    -                 -
//
// one byte is taken per cycle while tready is high; results are queued the next cycle
// a key-off that empties the voice count gives two words, a key-off then an all-off
// s_axis_tready drops when the four-entry result queue has fewer than two free slots
// synchronous active-low reset returns to awaiting a command byte with a skip count of 6
module midi_note_event_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // note_or_value, attenuation
    output logic [1:0]  m_axis_tuser,   // event_code
    output logic        m_axis_tlast,   // last_of_run
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data
);
    import mnep_pkg::*;

    push_t     push;
    result_t   head;
    q_status_t q_stat;
    logic      in_accept;
    logic      pop;

    assign s_axis_tready = (q_stat.count <= 3'd2);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (q_stat.count != 3'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;

    mnep_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .rx_byte     (s_axis_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push)
    );

    mnep_out_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .status  (q_stat)
    );

    assign m_axis_tdata = {head.attenuation, head.note_or_value};
    assign m_axis_tuser = head.code;
    assign m_axis_tlast = head.last;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= 3'd4)
        else $error("result queue overflow");

    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n != 2'd0) |-> in_accept)
        else $error("results produced without an accepted word");

    a_pair_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n == 2'd2) |-> (!push.r0.last && push.r1.last &&
                              push.r0.code == EV_KEY_OFF && push.r1.code == EV_ALL_OFF))
        else $error("malformed key-off and all-off pair");

    a_tvalid_after_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n != 2'd0) |=> m_axis_tvalid)
        else $error("queued result not presented");
`endif

endmodule

>>> sim/tb_top.sv
// self-checking testbench for the midi note event parser, stream in and out
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mnep_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_MOSTLY,
        RDY_STALLS
    } ready_mode_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // note_or_value, attenuation
    logic [1:0]  m_axis_tuser;           // event_code
    logic        m_axis_tlast;           // last_of_run
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_wr_data = 4'd0;     // control_skip_count

    midi_note_event_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // bytes waiting to be driven and events the parser should give back
    logic [7:0] rx_bytes[$];
    result_t    expected_events[$];
    int         bytes_queued   = 0;
    int         bytes_accepted = 0;
    int         error_count    = 0;
    int         cycle_count    = 0;
    logic       byte_taken     = 1'b0;

    // predicted parser state
    phase_t     parse_state;
    logic [7:0] key_hold;
    logic [7:0] voice_tally;
    logic [7:0] note_hold;
    logic [7:0] atten_hold;
    logic [3:0] skip_left;
    logic [3:0] ctrl_skip;

    // what the stimulus side believes the skip count is
    int         skip_setting = 6;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void add_event(input ev_code_t code, input logic last);
        result_t ev;
        ev.code          = code;
        ev.note_or_value = note_hold;
        ev.attenuation   = atten_hold;
        ev.last          = last;
        expected_events.push_back(ev);
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        int diff;
        case (parse_state)
            PH_KEY: begin
                key_hold    = b;
                parse_state = PH_VEL;
            end
            PH_VEL: begin
                parse_state = PH_IDLE;
                note_hold   = key_hold;
                if (b != 8'd0) begin
                    diff        = int'(VEL_MAX) - int'(b);
                    atten_hold  = 8'(diff / 5);
                    voice_tally = voice_tally + 8'd1;
                    add_event(EV_KEY_ON, 1'b1);
                end else begin
                    voice_tally = voice_tally - 8'd1;
                    if (voice_tally == 8'd0) begin
                        add_event(EV_KEY_OFF, 1'b0);
                        add_event(EV_ALL_OFF, 1'b1);
                    end else begin
                        add_event(EV_KEY_OFF, 1'b1);
                    end
                end
            end
            PH_SKIP: begin
                if (skip_left > 4'd1) begin
                    skip_left = skip_left - 4'd1;
                end else begin
                    skip_left   = 4'd0;
                    parse_state = PH_IDLE;
                    note_hold   = b;
                    add_event(EV_CTRL, 1'b1);
                end
            end
            default: begin
                parse_state = PH_IDLE;
                if (b == ST_NOTE_ON) begin
                    parse_state = PH_KEY;
                end else if (b == ST_CTRL) begin
                    // a zero count still reads one byte
                    skip_left   = (ctrl_skip == 4'd0) ? 4'd1 : ctrl_skip;
                    parse_state = PH_SKIP;
                end else if (b != ST_ALIVE) begin
                    key_hold    = b;
                    parse_state = PH_VEL;
                end
            end
        endcase
    endtask

    // monitor: prediction on accepted input, checking on accepted output
    always @(posedge aclk) begin : watch
        result_t want;
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("midi_note_event_parser test failed");
            $finish;
        end else begin
            byte_taken = 1'b0;
            if (!aresetn) begin
                parse_state = PH_IDLE;
                key_hold    = 8'd0;
                voice_tally = 8'd0;
                note_hold   = 8'd0;
                atten_hold  = 8'd0;
                skip_left   = 4'd0;
                ctrl_skip   = CTRL_SKIP_RESET;
            end else begin
                if (cfg_wr_en)
                    ctrl_skip = cfg_wr_data;
                if (m_axis_tvalid && m_axis_tready) begin
                    if (expected_events.size() == 0) begin
                        $error("unexpected word: tuser %h tdata %h tlast %b",
                               m_axis_tuser, m_axis_tdata, m_axis_tlast);
                        error_count++;
                    end else begin
                        want = expected_events.pop_front();
                        if (m_axis_tuser != want.code) begin
                            $error("event_code: expected %0d, got %0d",
                                   want.code, m_axis_tuser);
                            error_count++;
                        end
                        if (m_axis_tdata[7:0] != want.note_or_value) begin
                            $error("note_or_value: expected %h, got %h",
                                   want.note_or_value, m_axis_tdata[7:0]);
                            error_count++;
                        end
                        if (m_axis_tdata[15:8] != want.attenuation) begin
                            $error("attenuation: expected %h, got %h",
                                   want.attenuation, m_axis_tdata[15:8]);
                            error_count++;
                        end
                        if (m_axis_tlast != want.last) begin
                            $error("last_of_run: expected %b, got %b",
                                   want.last, m_axis_tlast);
                            error_count++;
                        end
                    end
                end
                if (s_axis_tvalid && s_axis_tready) begin
                    byte_taken     = 1'b1;
                    bytes_accepted = bytes_accepted + 1;
                    parse_byte(s_axis_tdata);
                end
            end
        end
    end

    // driver: bursts of words with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge aclk) begin : drive_input
        logic       valid_next;
        logic [7:0] data_next;
        valid_next = s_axis_tvalid;
        data_next  = s_axis_tdata;
        if (!aresetn) begin
            valid_next = 1'b0;
        end else if (!s_axis_tvalid || byte_taken) begin
            valid_next = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (rx_bytes.size() > 0) begin
                valid_next = 1'b1;
                data_next  = rx_bytes.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    // a third of the bursts run straight on
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end
        end
        s_axis_tvalid <= valid_next;
        s_axis_tdata  <= data_next;
    end

    // receiver back-pressure, switching pattern every so often
    ready_mode_t ready_mode = RDY_ALWAYS;
    int          mode_left  = 0;
    int          stall_left = 0;

    always @(negedge aclk) begin : drive_ready
        logic ready_next;
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            RDY_ALWAYS: ready_next = 1'b1;
            RDY_COIN:   ready_next = 1'($urandom_range(0, 1));
            RDY_MOSTLY: ready_next = ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    ready_next = 1'b0;
                end else begin
                    ready_next = 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(1, 16);
                end
            end
        endcase
        m_axis_tready <= ready_next;
    end

    task automatic queue_byte(input logic [7:0] b);
        rx_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (bytes_accepted != bytes_queued || expected_events.size() != 0);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    task automatic write_skip(input int n);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 4'(n);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        skip_setting = n;
    endtask

    function automatic logic [7:0] pick_velocity();
        return ($urandom_range(0, 99) < 45) ? 8'd0 : 8'($urandom_range(1, 255));
    endfunction

    // one message, mostly well formed; returns the number of bytes that count
    task automatic queue_random_message(output int counted);
        int         pick;
        int         n;
        logic [7:0] k;
        pick    = $urandom_range(0, 99);
        counted = 0;
        if (pick < 40) begin
            queue_byte(ST_NOTE_ON);
            queue_byte(8'($urandom_range(0, 255)));
            queue_byte(pick_velocity());
            counted = 3;
        end else if (pick < 65) begin
            // running status key
            do
                k = 8'($urandom_range(0, 255));
            while (k == ST_NOTE_ON || k == ST_CTRL || k == ST_ALIVE);
            queue_byte(k);
            queue_byte(pick_velocity());
            counted = 2;
        end else if (pick < 80) begin
            n = (skip_setting == 0) ? 1 : skip_setting;
            // occasionally cut short or run over
            if ($urandom_range(0, 9) == 0)
                n = n + $urandom_range(0, 2) - 1;
            queue_byte(ST_CTRL);
            repeat (n) queue_byte(8'($urandom_range(0, 255)));
            counted = 1 + n;
        end else if (pick < 88) begin
            queue_byte(ST_ALIVE);
        end else begin
            queue_byte(8'($urandom_range(0, 255)));
            counted = 1;
        end
    endtask

    task automatic queue_random_run(input int target);
        int total;
        int c;
        total = 0;
        while (total < target) begin
            queue_random_message(c);
            total += c;
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part at the reset skip count
        queue_byte(ST_ALIVE);
        queue_byte(ST_NOTE_ON); queue_byte(8'h00); queue_byte(8'h7F);
        queue_byte(8'h22); queue_byte(8'h01);
        queue_byte(ST_NOTE_ON); queue_byte(8'h7F); queue_byte(8'hFF);
        // three key-offs empty the voices, a fourth wraps the count
        queue_byte(ST_NOTE_ON); queue_byte(8'h3C); queue_byte(8'h00);
        queue_byte(8'h3C); queue_byte(8'h00);
        queue_byte(8'h3C); queue_byte(8'h00);
        queue_byte(8'h3C); queue_byte(8'h00);
        // key-on wraps the count back to zero
        queue_byte(8'h10); queue_byte(8'h50);
        // status-looking bytes inside a control or note-on message are data
        queue_byte(ST_CTRL);
        queue_byte(ST_ALIVE); queue_byte(ST_NOTE_ON); queue_byte(ST_CTRL);
        queue_byte(8'h01); queue_byte(8'h02); queue_byte(8'h7F);
        queue_byte(ST_NOTE_ON); queue_byte(ST_ALIVE); queue_byte(ST_CTRL);
        wait_drained();

        write_skip(1);
        queue_random_run(120);
        wait_drained();

        write_skip(15);
        queue_random_run(120);
        wait_drained();

        write_skip(0);
        queue_random_run(100);
        wait_drained();

        write_skip($urandom_range(2, 14));
        queue_random_run(60);
        // sender holds off mid-message until everything has come back
        queue_byte(ST_NOTE_ON);
        queue_byte(8'h22);
        wait_drained();
        queue_byte(8'h00);
        queue_random_run(60);
        wait_drained();

        write_skip(6);
        queue_random_run(140);
        wait_drained();

        if (error_count == 0)
            $display("midi_note_event_parser test passed");
        else
            $display("midi_note_event_parser test failed");
        $finish;
    end

endmodule
